[hdl/ilid_pkg.sv]
// Shared types, constants and codes for the indexed list insert/delete unit.
package ilid_pkg;

  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);
  localparam int PosW = 7;
  localparam int DataW = 32;

  typedef enum logic [2:0] {
    CMD_READ     = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_INS_AT   = 3'd3,
    CMD_DELETE   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [1:0]              status;
    logic [PosW-1:0]         count;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_REPLY
  } state_t;

  // Per-item decode held in the datapath.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } op_t;

  typedef struct packed {
    logic load;       // capture the item and decode it
    logic step;       // one read or write phase of a shift move
    logic finish;     // final write and length update
    logic reply;      // drive result strobe
  } dp_cmd_t;

  typedef struct packed {
    logic move_done;  // no more shift moves left
  } dp_stat_t;

endpackage

[hdl/indexed_list_insert_delete_unit.sv]
// Top level of the indexed list insert/delete unit.
// Keeps an ordered list of up to 64 signed 32-bit values in an entry memory.
// An item (cmd, position, value) is transferred at a rising edge with start
// high and busy low. busy is high from the cycle after the transfer up to the
// result strobe cycle; it is low again in that cycle, so the next item can be
// transferred at the same edge that takes the result.
// Exactly one result per item appears on out_item for one cycle with
// out_valid high; the receiver cannot stall it.
// An insert at position p with length n moves n-p entries, a delete moves
// n-p-1 entries; each move is a memory read, then a write.
// Items are handled one at a time; a new item is taken only while busy is low.
// Reset (rst_n low, synchronous) empties the list and idles the controller;
// entry contents are not cleared since they are read only after written.
module indexed_list_insert_delete_unit
  import ilid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  ilid_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .dp_cmd  (dp_cmd),
    .dp_stat (dp_stat)
  );

  ilid_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[hdl/ilid_ctrl.sv]
// Controller FSM of the indexed list insert/delete unit.
module ilid_ctrl
  import ilid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_MOVE;
      S_MOVE:  if (dp_stat.move_done) state_nxt = S_REPLY;
      S_REPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b1;
    dp_cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        dp_cmd.load = start;
      end
      S_MOVE: begin
        dp_cmd.step   = !dp_stat.move_done;
        dp_cmd.finish = dp_stat.move_done;
      end
      S_REPLY: dp_cmd.reply = 1'b1;
      default: ;
    endcase
  end

  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !busy) else $error("busy while idle");
  a_reply_once: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.reply |=> !dp_cmd.reply) else $error("double reply");
  a_load_to_move: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load |=> (state_r == S_MOVE)) else $error("load without move");

endmodule

[hdl/ilid_dp.sv]
// Datapath: entry memory, length, shift sequencing and result register.
module ilid_dp
  import ilid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   dp_cmd,
  output dp_stat_t  dp_stat,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [DataW-1:0] mem [Depth];

  logic [CountW-1:0] len_r;
  op_t               op_r;
  status_t           st_r;
  logic [AddrW-1:0]  tgt_r;      // insert/delete/read position
  logic [CountW-1:0] ptr_r;      // current move index
  logic signed [DataW-1:0] val_r;
  logic [DataW-1:0]  rdata_r;
  logic              phase_r;    // 0: read issued, 1: data ready to write
  logic              rd_miss_r;  // read past the end
  logic              out_valid_r;
  out_item_t         out_r;

  logic [PosW-1:0]   pos;
  logic              full, range_ins, range_rd;
  logic [CountW-1:0] ins_pos;

  op_t               op_ld;
  status_t           st_ld;
  logic [AddrW-1:0]  tgt_ld;
  logic [CountW-1:0] ptr_ld;

  assign pos       = in_item.position;
  assign full      = (len_r == CountW'(Depth));
  assign ins_pos   = (in_item.cmd == CMD_INS_HEAD) ? '0 :
                     (in_item.cmd == CMD_INS_TAIL) ? len_r : CountW'(pos);
  assign range_ins = ({1'b0, ins_pos} > {1'b0, len_r}) || (pos > PosW'(Depth) &&
                     in_item.cmd == CMD_INS_AT);
  assign range_rd  = (CountW'(pos) >= len_r) || (32'(pos) >= 32'(Depth));

  // Decode of the item taken at load.
  always_comb begin
    op_ld  = OP_NONE;
    st_ld  = ST_DONE;
    tgt_ld = AddrW'(pos);
    ptr_ld = CountW'(pos);
    unique case (in_item.cmd) inside
      CMD_READ: begin
        if (range_rd) st_ld = ST_RANGE;
        else          op_ld = OP_READ;
      end
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        tgt_ld = AddrW'(ins_pos);
        ptr_ld = len_r;
        if (range_ins)  st_ld = ST_RANGE;
        else if (full)  st_ld = ST_FULL;
        else            op_ld = OP_INSERT;
      end
      CMD_DELETE: begin
        if (range_rd) st_ld = ST_RANGE;
        else          op_ld = OP_DELETE;
      end
      default: ;
    endcase
  end

  // insert: ptr walks from len down to tgt+1 copying mem[ptr-1] -> mem[ptr]
  // delete: ptr walks from tgt up to len-2 copying mem[ptr+1] -> mem[ptr]
  logic [AddrW-1:0] src_a, dst_a;
  always_comb begin
    if (op_r == OP_INSERT) begin
      src_a = AddrW'(ptr_r - 1'b1);
      dst_a = AddrW'(ptr_r);
    end else begin
      src_a = AddrW'(ptr_r + 1'b1);
      dst_a = AddrW'(ptr_r);
    end
  end

  always_comb begin
    unique case (op_r)
      OP_INSERT: dp_stat.move_done = (ptr_r == CountW'(tgt_r));
      OP_DELETE: dp_stat.move_done = (ptr_r + 1'b1 >= len_r);
      OP_READ:   dp_stat.move_done = phase_r;
      default:   dp_stat.move_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[(op_r == OP_READ) ? tgt_r : src_a];
    if (dp_cmd.step && phase_r && op_r != OP_READ) mem[dst_a] <= rdata_r;
    else if (dp_cmd.finish && op_r == OP_INSERT) mem[tgt_r] <= val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      op_r        <= OP_NONE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_cmd.reply;
      if (dp_cmd.load) begin
        phase_r   <= 1'b0;
        val_r     <= in_item.value;
        st_r      <= st_ld;
        op_r      <= op_ld;
        tgt_r     <= tgt_ld;
        ptr_r     <= ptr_ld;
        rd_miss_r <= (in_item.cmd == CMD_READ) && range_rd;
      end else if (dp_cmd.step) begin
        phase_r <= !phase_r;
        if (phase_r) begin
          if (op_r == OP_INSERT) ptr_r <= ptr_r - 1'b1;
          else                   ptr_r <= ptr_r + 1'b1;
        end
      end else if (dp_cmd.finish) begin
        if (op_r == OP_INSERT)      len_r <= len_r + 1'b1;
        else if (op_r == OP_DELETE) len_r <= len_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.finish) begin
      out_r.status <= st_r;
      if (op_r == OP_READ) out_r.read_value <= rdata_r;
      else if (rd_miss_r)  out_r.read_value <= '1;
      else                 out_r.read_value <= '0;
      case (op_r)
        OP_INSERT: out_r.count <= PosW'(len_r + 1'b1);
        OP_DELETE: out_r.count <= PosW'(len_r - 1'b1);
        default:   out_r.count <= PosW'(len_r);
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CountW'(Depth)) else $error("length overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.finish && st_r == ST_FULL) |=> $stable(len_r)) else $error("full changed length");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.step && dp_cmd.finish)) else $error("step and finish together");

endmodule

[sim/indexed_list_checker.sv]
// Checker for the indexed list unit: watches transfers, models the list, compares results.
`timescale 1ns / 100ps
module indexed_list_checker
  import ilid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  logic signed [DataW-1:0] list_q [Depth];
  int unsigned list_len;
  out_item_t expected_results [$];

  // Insert before pos; returns status.
  function automatic status_t list_insert(int unsigned pos, logic signed [DataW-1:0] v);
    if (pos > list_len) return ST_RANGE;
    if (list_len >= Depth) return ST_FULL;
    for (int unsigned i = list_len; i > pos; i--) list_q[i] = list_q[i-1];
    list_q[pos] = v;
    list_len++;
    return ST_DONE;
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t r;
    r = '0;
    r.status = ST_DONE;
    case (it.cmd)
      CMD_READ: begin
        if (it.position < list_len) begin
          r.read_value = list_q[it.position];
        end else begin
          r.read_value = -1;
          r.status = ST_RANGE;
        end
      end
      CMD_INS_HEAD: r.status = list_insert(0, it.value);
      CMD_INS_TAIL: r.status = list_insert(list_len, it.value);
      CMD_INS_AT: r.status = list_insert(it.position, it.value);
      CMD_DELETE: begin
        if (it.position >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int unsigned i = it.position; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
          list_len--;
        end
      end
      default: ;
    endcase
    r.count = list_len[PosW-1:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_item.read_value);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
          if (out_item.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_item.count);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_command(in_item));
    end
  end

endmodule

[sim/indexed_list_insert_delete_unit_test.sv]
// Testbench top for the indexed list unit: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module indexed_list_insert_delete_unit_test;
  import ilid_pkg::*;

  localparam int WatchdogLimit = 2000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        idle_cycles;
  int        shadow_len;  // length tracked by stimulus, to steer positions

  indexed_list_insert_delete_unit dut (.*);

  indexed_list_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Present one item and hold it until transferred; random gaps first when may_idle is set.
  task automatic issue(logic [2:0] cmd, logic [PosW-1:0] pos, logic signed [DataW-1:0] v,
                       bit may_idle);
    while (may_idle && $urandom_range(99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{cmd: cmd, position: pos, value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
    case (cmd) inside
      CMD_INS_HEAD, CMD_INS_TAIL: if (shadow_len < Depth) shadow_len++;
      CMD_INS_AT: if (pos <= shadow_len && shadow_len < Depth) shadow_len++;
      CMD_DELETE: if (pos < shadow_len) shadow_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [DataW-1:0] rand_value();
    case ($urandom_range(4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [2:0] cmd;
    logic [PosW-1:0] pos;
    int fill_bias;
    rst_n = 0;
    start = 0;
    in_item = '0;
    shadow_len = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: empty-list failures, extremes, unknown commands.
    issue(CMD_READ, 0, 0, 0);
    issue(CMD_DELETE, 0, 0, 0);
    issue(CMD_INS_AT, 1, 5, 0);
    issue(CMD_INS_HEAD, 0, 32'sh7fffffff, 0);
    issue(CMD_INS_TAIL, 0, 32'sh80000000, 0);
    issue(CMD_INS_AT, 1, -1, 0);
    issue(CMD_INS_AT, 3, 123, 0);
    issue(CMD_READ, 0, 0, 0);
    issue(CMD_READ, 2, 0, 0);
    issue(CMD_READ, 3, 0, 0);
    issue(CMD_READ, 7'h7f, 32'hffffffff, 0);
    issue(3'd5, 7'h7f, 32'hffffffff, 0);
    issue(3'd6, 0, 0, 0);
    issue(3'd7, 1, 1, 0);
    issue(CMD_DELETE, 2, 0, 0);
    issue(CMD_DELETE, 7'h7f, 0, 0);
    // Fill to full, then hit the full-store and range cases.
    while (shadow_len < Depth) issue(CMD_INS_TAIL, 0, $urandom, 0);
    issue(CMD_INS_HEAD, 0, 1, 0);
    issue(CMD_INS_TAIL, 0, 2, 0);
    issue(CMD_INS_AT, 64, 3, 0);
    issue(CMD_INS_AT, 65, 3, 0);
    issue(CMD_READ, 63, 0, 0);
    issue(CMD_READ, 64, 0, 0);
    issue(CMD_DELETE, 63, 0, 0);
    issue(CMD_DELETE, 0, 0, 0);
    // Random: bias alternates between growing and shrinking to sweep the length.
    for (int n = 0; n < 565; n++) begin
      fill_bias = ((n / 120) % 2 == 0) ? 65 : 30;
      if ($urandom_range(99) < 5) cmd = 3'($urandom_range(5, 7));
      else if ($urandom_range(99) < fill_bias) cmd = 3'($urandom_range(1, 3));
      else cmd = ($urandom_range(1)) ? CMD_READ : CMD_DELETE;
      if ($urandom_range(9) == 0) pos = PosW'($urandom);
      else pos = PosW'($urandom_range(shadow_len));
      issue(cmd, pos, rand_value(), !(n >= 200 && n < 300));
    end
    issue(CMD_READ, 0, 0, 0);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog on cycles with neither a transfer nor a result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[filelist.f]
hdl/ilid_pkg.sv
hdl/ilid_ctrl.sv
hdl/ilid_dp.sv
hdl/indexed_list_insert_delete_unit.sv
sim/indexed_list_checker.sv
sim/indexed_list_insert_delete_unit_test.sv
